// ----- hw/rtl/ccpf_pkg.sv -----
// Package of the calibrated control packet framer: payload types, frame
// constants and register indexes. No dependencies.
package ccpf_pkg;

   localparam int LEVEL_WIDTH     = 10;
   localparam int SWITCH_WIDTH    = 6;
   localparam int MASK_WIDTH      = 8;
   localparam int CAL_WIDTH       = 30;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int BYTE_INDEX_WIDTH = 5;
   localparam int FRAME_LEN       = 20;

   // Divider: 19-bit magnitude numerator, 10-bit divisor, 12 quotient bits
   // (the top one flags a quotient that saturates the clamp).
   localparam int NUM_WIDTH   = 19;
   localparam int DEN_WIDTH   = 10;
   localparam int QUO_WIDTH   = 12;
   localparam int DIV_STAGES  = 4;
   localparam int STEPS_PER_STAGE = QUO_WIDTH / DIV_STAGES;

   localparam logic [7:0] START_BYTE0 = 8'hF1;
   localparam logic [7:0] START_BYTE1 = 8'h7E;
   localparam logic [LEVEL_WIDTH-1:0] CAL_MID   = 10'd512;
   localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = 10'd1023;
   localparam logic [CAL_WIDTH-1:0]   CAL_RESET = 30'h3FF80000;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CAL_STICK1_UD = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CAL_STICK1_LR = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CAL_STICK2_UD = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CAL_STICK2_LR = 8'd3;

   localparam logic [BYTE_INDEX_WIDTH-1:0] LAST_BYTE = 5'd19;

   typedef struct packed {
      logic [NUM_WIDTH-1:0] rem;
      logic [QUO_WIDTH-1:0] quo;
      logic [DEN_WIDTH-1:0] den;
      logic                 neg;
      logic                 zero;
      logic                 upper;
   } div_type;

   typedef struct packed {
      logic [LEVEL_WIDTH-1:0]  poti_level;
      logic [LEVEL_WIDTH-1:0]  flap_level;
      logic [LEVEL_WIDTH-1:0]  fader_level;
      logic [SWITCH_WIDTH-1:0] switch_bits;
      logic [MASK_WIDTH-1:0]   button_mask;
      logic [MASK_WIDTH-1:0]   special_mask;
   } pass_type;

endpackage

// ----- hw/rtl/ccpf_if.sv -----
// Channel interfaces of the framer: sample set, frame byte and register write.
// Depends on ccpf_pkg.
interface ccpf_req_if;
   logic                                valid;
   logic                                ready;
   logic [ccpf_pkg::LEVEL_WIDTH-1:0]    stick1_ud;
   logic [ccpf_pkg::LEVEL_WIDTH-1:0]    stick1_lr;
   logic [ccpf_pkg::LEVEL_WIDTH-1:0]    stick2_ud;
   logic [ccpf_pkg::LEVEL_WIDTH-1:0]    stick2_lr;
   logic [ccpf_pkg::LEVEL_WIDTH-1:0]    poti_level;
   logic [ccpf_pkg::LEVEL_WIDTH-1:0]    flap_level;
   logic [ccpf_pkg::LEVEL_WIDTH-1:0]    fader_level;
   logic [ccpf_pkg::SWITCH_WIDTH-1:0]   switch_bits;
   logic [ccpf_pkg::MASK_WIDTH-1:0]     button_mask;
   logic [ccpf_pkg::MASK_WIDTH-1:0]     special_mask;

   modport source (output valid, stick1_ud, stick1_lr, stick2_ud, stick2_lr,
                   poti_level, flap_level, fader_level, switch_bits,
                   button_mask, special_mask, input ready);
   modport sink (input valid, stick1_ud, stick1_lr, stick2_ud, stick2_lr,
                 poti_level, flap_level, fader_level, switch_bits,
                 button_mask, special_mask, output ready);
endinterface

interface ccpf_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [7:0]                             frame_byte;
   logic [ccpf_pkg::BYTE_INDEX_WIDTH-1:0]  byte_index;
   logic                                   frame_end;

   modport source (output valid, frame_byte, byte_index, frame_end, input ready);
   modport sink (input valid, frame_byte, byte_index, frame_end, output ready);
endinterface

interface ccpf_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [ccpf_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic [ccpf_pkg::CSR_DATA_WIDTH-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ccpf_axis_cal.sv -----
// Piecewise-linear calibration of one axis: set-up stage, pipelined restoring
// divider and clamp. Depends on ccpf_pkg.
module ccpf_axis_cal (
   input  logic                                 clock,
   input  logic                                 advance,
   input  logic [ccpf_pkg::LEVEL_WIDTH-1:0]     raw,
   input  logic [ccpf_pkg::CAL_WIDTH-1:0]       cal,
   output logic [ccpf_pkg::LEVEL_WIDTH-1:0]     value
);

   ccpf_pkg::div_type div_ff [0:ccpf_pkg::DIV_STAGES];
   ccpf_pkg::div_type div_in [0:ccpf_pkg::DIV_STAGES];
   ccpf_pkg::div_type setup_in;

   logic [9:0]  lo, mid, hi;
   logic        upper;
   logic [10:0] diff, den;
   logic [9:0]  diff_mag, den_mag;

   // One quotient bit per step, most significant first.
   function automatic ccpf_pkg::div_type div_steps(ccpf_pkg::div_type d, int first);
      ccpf_pkg::div_type r;
      logic [20:0] dd;
      int          s;
      r = d;
      for (int j = 0; j < ccpf_pkg::STEPS_PER_STAGE; j++) begin
         s  = ccpf_pkg::QUO_WIDTH - 1 - (first + j);
         dd = {11'd0, r.den} << s;
         if ({2'b00, r.rem} >= dd) begin
            r.rem    = r.rem - dd[ccpf_pkg::NUM_WIDTH-1:0];
            r.quo[s] = 1'b1;
         end
      end
      return r;
   endfunction

   // Set-up: pick the branch, form numerator and divisor magnitudes.
   always_comb begin
      lo    = cal[9:0];
      mid   = cal[19:10];
      hi    = cal[29:20];
      upper = raw > mid;
      diff  = upper ? ({1'b0, raw} - {1'b0, mid}) : ({1'b0, raw} - {1'b0, lo});
      den   = upper ? ({1'b0, hi} - {1'b0, mid}) : ({1'b0, mid} - {1'b0, lo});
      diff_mag = diff[10] ? 10'(-diff) : diff[9:0];
      den_mag  = den[10] ? 10'(-den) : den[9:0];
      setup_in.rem   = {diff_mag, 9'd0};
      setup_in.quo   = '0;
      setup_in.den   = den_mag;
      setup_in.neg   = diff[10] ^ den[10];
      setup_in.zero  = (den == 11'd0);
      setup_in.upper = upper;
   end

   assign div_in[0] = setup_in;

   for (genvar g = 1; g <= ccpf_pkg::DIV_STAGES; g++) begin : g_div
      assign div_in[g] = div_steps(div_ff[g-1], (g - 1) * ccpf_pkg::STEPS_PER_STAGE);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= ccpf_pkg::DIV_STAGES; k++) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // Clamp: a quotient of 1024 or more saturates either branch.
   always_comb begin
      ccpf_pkg::div_type d;
      logic [10:0] q;
      d = div_ff[ccpf_pkg::DIV_STAGES];
      q = d.quo[11] ? 11'd1024 : {1'b0, d.quo[9:0]} | {d.quo[10], 10'd0};
      if (d.zero) begin
         value = ccpf_pkg::CAL_MID;
      end else if (!d.upper) begin
         if (d.neg) value = '0;
         else if (q > 11'd1023) value = ccpf_pkg::LEVEL_MAX;
         else value = q[9:0];
      end else begin
         if (d.neg) value = (q >= 11'd512) ? 10'd0 : 10'(11'd512 - q);
         else value = (q >= 11'd512) ? ccpf_pkg::LEVEL_MAX : 10'(11'd512 + q);
      end
   end

endmodule

// ----- hw/rtl/calibrated_control_packet_framer_unit.sv -----
// Calibrated control packet framer: sample set in, 20-byte frame out.
// The set-up register and the divider stages lie between a sample set beat
// and the frame register that offers its first byte. The output port gives
// one frame byte per beat; the whole pipeline holds while the frame register
// drains, so sets enter back to back only while that register is empty.
// Reset (synchronous, active high): pipeline and frame emptied, calibration
// registers return to min 0, centre 512, max 1023.
module calibrated_control_packet_framer_unit (
   input  logic          clock,
   input  logic          reset,
   ccpf_req_if.sink      req_chan,
   ccpf_rsp_if.source    rsp_chan,
   ccpf_csr_if.sink      csr_chan
);

   localparam int NSTAGE = ccpf_pkg::DIV_STAGES + 1;

   // Calibration registers; the user is to write them only while the block is idle, which the block does not enforce.
   logic [ccpf_pkg::CAL_WIDTH-1:0] cal_ff [0:3];

   // Pipeline: set-up stage then the divider stages, valid bits alongside.
   logic [NSTAGE-1:0]   valid_ff;
   ccpf_pkg::pass_type  pass_ff [0:NSTAGE-1];
   logic                advance;

   // Frame register and byte pointer: the output stage.
   logic [7:0]                              frame_ff [0:ccpf_pkg::FRAME_LEN-1];
   logic [7:0]                              frame_in [0:ccpf_pkg::FRAME_LEN-1];
   logic                                    frame_valid_ff;
   logic [ccpf_pkg::BYTE_INDEX_WIDTH-1:0]   idx_ff;

   logic [ccpf_pkg::LEVEL_WIDTH-1:0] axis_raw [0:3];
   logic [ccpf_pkg::LEVEL_WIDTH-1:0] axis_val [0:3];

   // Configuration port: always ready; drop writes beyond the list.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            cal_ff[k] <= ccpf_pkg::CAL_RESET;
         end
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            ccpf_pkg::REG_CAL_STICK1_UD: cal_ff[0] <= csr_chan.data[ccpf_pkg::CAL_WIDTH-1:0];
            ccpf_pkg::REG_CAL_STICK1_LR: cal_ff[1] <= csr_chan.data[ccpf_pkg::CAL_WIDTH-1:0];
            ccpf_pkg::REG_CAL_STICK2_UD: cal_ff[2] <= csr_chan.data[ccpf_pkg::CAL_WIDTH-1:0];
            ccpf_pkg::REG_CAL_STICK2_LR: cal_ff[3] <= csr_chan.data[ccpf_pkg::CAL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Advance the whole pipeline whenever the frame register is free or is
   // handing over its last byte in this cycle; otherwise hold every stage.
   assign advance = !frame_valid_ff || (rsp_chan.ready && idx_ff == ccpf_pkg::LAST_BYTE);
   assign req_chan.ready = advance;

   // Mirror axis two before calibration.
   assign axis_raw[0] = req_chan.stick1_ud;
   assign axis_raw[1] = ccpf_pkg::LEVEL_MAX - req_chan.stick1_lr;
   assign axis_raw[2] = req_chan.stick2_ud;
   assign axis_raw[3] = req_chan.stick2_lr;

   for (genvar a = 0; a < 4; a++) begin : g_axis
      ccpf_axis_cal u_cal (
         .clock   (clock),
         .advance (advance),
         .raw     (axis_raw[a]),
         .cal     (cal_ff[a]),
         .value   (axis_val[a])
      );
   end

   // Pass-through fields ride along with the divider.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NSTAGE-2:0], req_chan.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pass_ff[0].poti_level   <= req_chan.poti_level;
         pass_ff[0].flap_level   <= req_chan.flap_level;
         pass_ff[0].fader_level  <= req_chan.fader_level;
         pass_ff[0].switch_bits  <= req_chan.switch_bits;
         pass_ff[0].button_mask  <= req_chan.button_mask;
         pass_ff[0].special_mask <= req_chan.special_mask;
         for (int k = 1; k < NSTAGE; k++) begin
            pass_ff[k] <= pass_ff[k-1];
         end
      end
   end

   // Assemble the frame, low byte first, and close it with the XOR checksum.
   always_comb begin
      ccpf_pkg::pass_type p;
      logic [7:0] sum;
      p = pass_ff[NSTAGE-1];
      frame_in[0] = ccpf_pkg::START_BYTE0;
      frame_in[1] = ccpf_pkg::START_BYTE1;
      for (int a = 0; a < 4; a++) begin
         frame_in[2 + 2*a] = axis_val[a][7:0];
         frame_in[3 + 2*a] = {6'd0, axis_val[a][9:8]};
      end
      frame_in[10] = p.poti_level[7:0];
      frame_in[11] = {6'd0, p.poti_level[9:8]};
      frame_in[12] = p.flap_level[7:0];
      frame_in[13] = {6'd0, p.flap_level[9:8]};
      frame_in[14] = p.fader_level[7:0];
      frame_in[15] = {6'd0, p.fader_level[9:8]};
      frame_in[16] = {2'd0, p.switch_bits};
      frame_in[17] = p.button_mask;
      frame_in[18] = p.special_mask;
      sum = '0;
      for (int i = 0; i < ccpf_pkg::FRAME_LEN - 1; i++) begin
         sum = sum ^ frame_in[i];
      end
      frame_in[ccpf_pkg::FRAME_LEN-1] = sum;
   end

   // Output stage: load a finished frame, then step one byte per beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= 1'b0;
         idx_ff         <= '0;
      end else if (advance) begin
         frame_valid_ff <= valid_ff[NSTAGE-1];
         idx_ff         <= '0;
      end else if (rsp_chan.ready) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && valid_ff[NSTAGE-1]) begin
         for (int i = 0; i < ccpf_pkg::FRAME_LEN; i++) begin
            frame_ff[i] <= frame_in[i];
         end
      end
   end

   assign rsp_chan.valid      = frame_valid_ff;
   assign rsp_chan.frame_byte = frame_ff[idx_ff];
   assign rsp_chan.byte_index = idx_ff;
   assign rsp_chan.frame_end  = (idx_ff == ccpf_pkg::LAST_BYTE);

endmodule

// ----- dv/tb_calibrated_control_packet_framer_unit.sv -----
// Testbench of the calibrated control packet framer: drives sample sets and
// calibration writes, and checks every frame byte against an in-bench model.
// Depends on ccpf_pkg, the ccpf channel interfaces and the framer RTL.
module tb_calibrated_control_packet_framer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES      = 4;
   localparam int CYCLE_LIMIT       = 2_000_000;
   localparam int END_SETTLE_CYCLES = 40;
   localparam int HOLD_OFF_CYCLES   = 300;
   localparam int PRESSURE_ITEMS    = 12;
   localparam int RANDOM_PHASES     = 8;
   localparam int ITEMS_PER_PHASE   = 52;
   localparam int NUM_CAL_REGS      = 4;
   localparam int CAL_SEL_WIDTH     = $clog2(NUM_CAL_REGS);
   localparam int NUM_WORDS         = 7;
   localparam logic [ccpf_pkg::CSR_INDEX_WIDTH-1:0] UNMAPPED_INDEX_LOW = 8'd4;
   localparam logic [ccpf_pkg::CSR_INDEX_WIDTH-1:0] UNMAPPED_INDEX_TOP = 8'hFF;

   typedef struct packed {
      logic [ccpf_pkg::LEVEL_WIDTH-1:0]  stick1_ud;
      logic [ccpf_pkg::LEVEL_WIDTH-1:0]  stick1_lr;
      logic [ccpf_pkg::LEVEL_WIDTH-1:0]  stick2_ud;
      logic [ccpf_pkg::LEVEL_WIDTH-1:0]  stick2_lr;
      logic [ccpf_pkg::LEVEL_WIDTH-1:0]  poti_level;
      logic [ccpf_pkg::LEVEL_WIDTH-1:0]  flap_level;
      logic [ccpf_pkg::LEVEL_WIDTH-1:0]  fader_level;
      logic [ccpf_pkg::SWITCH_WIDTH-1:0] switch_bits;
      logic [ccpf_pkg::MASK_WIDTH-1:0]   button_mask;
      logic [ccpf_pkg::MASK_WIDTH-1:0]   special_mask;
   } sample_type;

   typedef struct packed {
      logic [7:0]                            frame_byte;
      logic [ccpf_pkg::BYTE_INDEX_WIDTH-1:0] byte_index;
      logic                                  frame_end;
   } frame_beat_type;

   logic clock = 1'b0;
   logic reset;

   ccpf_req_if req_chan();
   ccpf_rsp_if rsp_chan();
   ccpf_csr_if csr_chan();

   calibrated_control_packet_framer_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Mirror of the calibration registers, updated on each accepted write beat to a mapped index
   logic [ccpf_pkg::CAL_WIDTH-1:0] cal_table [NUM_CAL_REGS];
   // Frame bytes still owed by the block, oldest first
   frame_beat_type       pending_frame_bytes [$];
   frame_beat_type       oldest;

   int error_count   = 0;
   int samples_sent  = 0;
   int bytes_checked = 0;
   int cal_settings  = 0;
   int cycle_count   = 0;
   // Idling controls: chance per beat of a gap or stall, in percent
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int stall_left    = 0;
   // Long receiver hold-off, loaded by a test and counted down below
   int hold_off_left = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Calibration and framing
   // ---------------------------------------------------------------------

   function automatic logic [ccpf_pkg::CAL_WIDTH-1:0] cal_of(
         input logic [ccpf_pkg::CSR_INDEX_WIDTH-1:0] idx);
      return cal_table[idx[CAL_SEL_WIDTH-1:0]];
   endfunction

   // Piecewise-linear map: 0..512 up to centre, 512..1024 above it, signed
   // division truncating toward zero, clamp to the 10-bit range.
   function automatic logic [ccpf_pkg::LEVEL_WIDTH-1:0] calibrate_axis(
         input logic [ccpf_pkg::LEVEL_WIDTH-1:0] raw,
         input logic [ccpf_pkg::CAL_WIDTH-1:0] cal);
      int x, lo, mid, hi, den, r;
      x   = int'(raw);
      lo  = int'(cal[ccpf_pkg::LEVEL_WIDTH-1:0]);
      mid = int'(cal[2*ccpf_pkg::LEVEL_WIDTH-1:ccpf_pkg::LEVEL_WIDTH]);
      hi  = int'(cal[3*ccpf_pkg::LEVEL_WIDTH-1:2*ccpf_pkg::LEVEL_WIDTH]);
      if (x <= mid) begin
         den = mid - lo;
         r = (den == 0) ? int'(ccpf_pkg::CAL_MID)
                        : (x - lo) * int'(ccpf_pkg::CAL_MID) / den;
      end else begin
         // the upper half spans 512 counts as well
         den = hi - mid;
         r = (den == 0) ? int'(ccpf_pkg::CAL_MID)
                        : (x - mid) * int'(ccpf_pkg::CAL_MID) / den
                          + int'(ccpf_pkg::CAL_MID);
      end
      if (r < 0) r = 0;
      if (r > int'(ccpf_pkg::LEVEL_MAX)) r = int'(ccpf_pkg::LEVEL_MAX);
      return r[ccpf_pkg::LEVEL_WIDTH-1:0];
   endfunction

   // Work out the 20 bytes a sample set produces and queue them
   function automatic void build_frame_bytes(input sample_type s);
      logic [7:0]  frame [ccpf_pkg::FRAME_LEN];
      logic [15:0] words [NUM_WORDS];
      logic [7:0]  check;
      frame_beat_type beat;
      words[0] = 16'(calibrate_axis(s.stick1_ud, cal_of(ccpf_pkg::REG_CAL_STICK1_UD)));
      // axis two is mirrored before calibration
      words[1] = 16'(calibrate_axis(ccpf_pkg::LEVEL_MAX - s.stick1_lr,
                                    cal_of(ccpf_pkg::REG_CAL_STICK1_LR)));
      words[2] = 16'(calibrate_axis(s.stick2_ud, cal_of(ccpf_pkg::REG_CAL_STICK2_UD)));
      words[3] = 16'(calibrate_axis(s.stick2_lr, cal_of(ccpf_pkg::REG_CAL_STICK2_LR)));
      words[4] = 16'(s.poti_level);
      words[5] = 16'(s.flap_level);
      words[6] = 16'(s.fader_level);
      frame[0] = ccpf_pkg::START_BYTE0;
      frame[1] = ccpf_pkg::START_BYTE1;
      for (int w = 0; w < NUM_WORDS; w++) begin
         frame[2 + 2*w] = words[w][7:0];
         frame[3 + 2*w] = words[w][15:8];
      end
      frame[16] = 8'(s.switch_bits);
      frame[17] = s.button_mask;
      frame[18] = s.special_mask;
      check = '0;
      for (int i = 0; i < ccpf_pkg::FRAME_LEN - 1; i++) check ^= frame[i];
      frame[ccpf_pkg::FRAME_LEN-1] = check;
      for (int i = 0; i < ccpf_pkg::FRAME_LEN; i++) begin
         beat.frame_byte = frame[i];
         beat.byte_index = i[ccpf_pkg::BYTE_INDEX_WIDTH-1:0];
         beat.frame_end  = (i == ccpf_pkg::FRAME_LEN - 1);
         pending_frame_bytes.push_back(beat);
      end
   endfunction

   function automatic logic [ccpf_pkg::CAL_WIDTH-1:0] pack_cal(input int lo, mid, hi);
      return {hi[ccpf_pkg::LEVEL_WIDTH-1:0], mid[ccpf_pkg::LEVEL_WIDTH-1:0],
              lo[ccpf_pkg::LEVEL_WIDTH-1:0]};
   endfunction

   // Register write word with the spare bits clear
   function automatic logic [ccpf_pkg::CSR_DATA_WIDTH-1:0] cal_word(input int lo, mid, hi);
      logic [ccpf_pkg::CSR_DATA_WIDTH-1:0] w;
      w = '0;
      w[ccpf_pkg::CAL_WIDTH-1:0] = pack_cal(lo, mid, hi);
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Random sources
   // ---------------------------------------------------------------------

   // Mostly short idle stretches, now and then a long one
   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   // Aim a reading at the knees of the calibration, the rails, or anywhere
   function automatic logic [ccpf_pkg::LEVEL_WIDTH-1:0] pick_axis(
         input logic [ccpf_pkg::CAL_WIDTH-1:0] cal);
      int v;
      case ($urandom_range(0, 7))
         0: v = int'(cal[ccpf_pkg::LEVEL_WIDTH-1:0]) + int'($urandom_range(0, 4)) - 2;
         1: v = int'(cal[2*ccpf_pkg::LEVEL_WIDTH-1:ccpf_pkg::LEVEL_WIDTH])
                + int'($urandom_range(0, 4)) - 2;
         2: v = int'(cal[3*ccpf_pkg::LEVEL_WIDTH-1:2*ccpf_pkg::LEVEL_WIDTH])
                + int'($urandom_range(0, 4)) - 2;
         3: v = 0;
         4: v = int'(ccpf_pkg::LEVEL_MAX);
         default: v = $urandom_range(0, 1023);
      endcase
      if (v < 0) v = 0;
      if (v > int'(ccpf_pkg::LEVEL_MAX)) v = int'(ccpf_pkg::LEVEL_MAX);
      return v[ccpf_pkg::LEVEL_WIDTH-1:0];
   endfunction

   function automatic sample_type random_sample();
      sample_type  s;
      logic [31:0] lv;
      logic [31:0] mk;
      lv = $urandom();
      mk = $urandom();
      s.stick1_ud    = pick_axis(cal_of(ccpf_pkg::REG_CAL_STICK1_UD));
      // hand over the reading that mirrors onto the chosen target
      s.stick1_lr    = ccpf_pkg::LEVEL_MAX - pick_axis(cal_of(ccpf_pkg::REG_CAL_STICK1_LR));
      s.stick2_ud    = pick_axis(cal_of(ccpf_pkg::REG_CAL_STICK2_UD));
      s.stick2_lr    = pick_axis(cal_of(ccpf_pkg::REG_CAL_STICK2_LR));
      s.poti_level   = lv[9:0];
      s.flap_level   = lv[19:10];
      s.fader_level  = lv[29:20];
      s.switch_bits  = mk[ccpf_pkg::SWITCH_WIDTH-1:0];
      s.button_mask  = mk[15:8];
      s.special_mask = mk[23:16];
      return s;
   endfunction

   // Fixed axis readings (axis two as raw, before mirroring), rest random
   function automatic sample_type axes_sample(input int a1, a2, a3, a4);
      sample_type s;
      s = random_sample();
      s.stick1_ud = a1[ccpf_pkg::LEVEL_WIDTH-1:0];
      s.stick1_lr = a2[ccpf_pkg::LEVEL_WIDTH-1:0];
      s.stick2_ud = a3[ccpf_pkg::LEVEL_WIDTH-1:0];
      s.stick2_lr = a4[ccpf_pkg::LEVEL_WIDTH-1:0];
      return s;
   endfunction

   // Mostly ordered calibrations, some degenerate, inconsistent or extreme;
   // the two spare bits above the register are filled at random.
   function automatic logic [ccpf_pkg::CSR_DATA_WIDTH-1:0] random_cal_word();
      int a, b, c, t, mode;
      logic [1:0] spare;
      logic [ccpf_pkg::CAL_WIDTH-1:0] cal;
      mode  = $urandom_range(0, 9);
      a     = $urandom_range(0, 1023);
      b     = $urandom_range(0, 1023);
      c     = $urandom_range(0, 1023);
      spare = 2'($urandom_range(0, 3));
      if (mode < 7) begin
         if (a > b) begin t = a; a = b; b = t; end
         if (b > c) begin t = b; b = c; c = t; end
         if (a > b) begin t = a; a = b; b = t; end
         if (mode == 6) begin
            if ($urandom_range(0, 1) == 0) b = a;
            else c = b;
         end
      end
      if (mode == 9) begin
         case ($urandom_range(0, 2))
            0: cal = '0;
            1: cal = '1;
            default: cal = ccpf_pkg::CAL_RESET;
         endcase
      end else begin
         cal = pack_cal(a, b, c);
      end
      return {spare, cal};
   endfunction

   // ---------------------------------------------------------------------
   // Channel drivers
   // ---------------------------------------------------------------------

   // Offer one sample set, optionally after a gap; valid stays high on
   // return so that a following set can go out on the very next beat.
   task automatic send_sample(input sample_type s);
      int gap;
      gap = ($urandom_range(0, 99) < req_gap_pct) ? gap_length() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.stick1_ud    <= s.stick1_ud;
      req_chan.stick1_lr    <= s.stick1_lr;
      req_chan.stick2_ud    <= s.stick2_ud;
      req_chan.stick2_lr    <= s.stick2_lr;
      req_chan.poti_level   <= s.poti_level;
      req_chan.flap_level   <= s.flap_level;
      req_chan.fader_level  <= s.fader_level;
      req_chan.switch_bits  <= s.switch_bits;
      req_chan.button_mask  <= s.button_mask;
      req_chan.special_mask <= s.special_mask;
      req_chan.valid        <= 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      build_frame_bytes(s);
      samples_sent++;
   endtask

   task automatic req_release();
      req_chan.valid <= 1'b0;
   endtask

   // Write one register; valid is left high, as for the sample channel
   task automatic write_cal(input logic [ccpf_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [ccpf_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      csr_chan.valid <= 1'b1;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      // indexes past the last register are dropped by the block
      if (idx <= ccpf_pkg::REG_CAL_STICK2_LR)
         cal_table[idx[CAL_SEL_WIDTH-1:0]] = value[ccpf_pkg::CAL_WIDTH-1:0];
   endtask

   task automatic csr_release();
      csr_chan.valid <= 1'b0;
   endtask

   // Hold until the last owed frame byte has been taken
   task automatic wait_drained();
      while (pending_frame_bytes.size() != 0) @(posedge clock);
   endtask

   task automatic set_calibration(input logic [ccpf_pkg::CSR_DATA_WIDTH-1:0] c0, c1, c2, c3);
      wait_drained();
      write_cal(ccpf_pkg::REG_CAL_STICK1_UD, c0);
      write_cal(ccpf_pkg::REG_CAL_STICK1_LR, c1);
      write_cal(ccpf_pkg::REG_CAL_STICK2_UD, c2);
      write_cal(ccpf_pkg::REG_CAL_STICK2_LR, c3);
      csr_release();
      cal_settings++;
   endtask

   // ---------------------------------------------------------------------
   // Receiver and checker
   // ---------------------------------------------------------------------

   // Drop ready for a long hold-off when a test asks for it, otherwise
   // stall at random for the current stall rate.
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if ($urandom_range(0, 99) < rsp_stall_pct) stall_left = gap_length();
      end
   end

   function automatic void check_field(input string what, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endfunction

   // Compare every accepted frame beat with the oldest owed byte
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_frame_bytes.size() == 0) begin
            error_count++;
            $display("%0t: frame_byte mismatch, expected none, actual %0h at index %0d",
                     $time, rsp_chan.frame_byte, rsp_chan.byte_index);
         end else begin
            oldest = pending_frame_bytes.pop_front();
            check_field("frame_byte", oldest.frame_byte, rsp_chan.frame_byte);
            check_field("byte_index", 8'(oldest.byte_index), 8'(rsp_chan.byte_index));
            check_field("frame_end", 8'(oldest.frame_end), 8'(rsp_chan.frame_end));
            bytes_checked++;
         end
      end
   end

   // Watchdog: stop a hung run after a generous number of cycles
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped after %0d cycles, %0d frame bytes still owed",
               cycle_count, pending_frame_bytes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Field extremes and the centre points under the calibration from reset
   task automatic test_reset_calibration();
      sample_type s;
      s = '0;
      send_sample(s);
      s = '1;
      send_sample(s);
      // 511 on axis two mirrors onto the centre
      send_sample(axes_sample(512, 511, 512, 512));
      s = axes_sample(513, 510, 1, 1022);
      s.switch_bits  = 6'h2A;
      s.button_mask  = 8'h55;
      s.special_mask = 8'hAA;
      send_sample(s);
      req_release();
   endtask

   // Spare data bits must be masked; writes to unmapped indexes must be lost
   task automatic test_register_index_range();
      wait_drained();
      write_cal(ccpf_pkg::REG_CAL_STICK1_UD, {2'b11, pack_cal(100, 400, 700)});
      write_cal(ccpf_pkg::REG_CAL_STICK1_LR, {2'b10, pack_cal(50, 600, 1000)});
      write_cal(ccpf_pkg::REG_CAL_STICK2_UD, {2'b01, pack_cal(0, 300, 900)});
      write_cal(ccpf_pkg::REG_CAL_STICK2_LR, {2'b11, pack_cal(200, 250, 800)});
      write_cal(UNMAPPED_INDEX_LOW, '0);
      write_cal(UNMAPPED_INDEX_TOP, '1);
      csr_release();
      cal_settings++;
      send_sample(axes_sample(100, 1023 - 600, 900, 250));
      send_sample(random_sample());
      req_release();
   endtask

   // Centre equal to min, or max equal to centre, must give mid-scale
   task automatic test_zero_denominator();
      set_calibration('0, '1, cal_word(300, 300, 900), cal_word(100, 600, 600));
      send_sample(axes_sample(0, 1023, 0, 0));
      send_sample(axes_sample(1, 0, 300, 600));
      send_sample(axes_sample(1023, 512, 301, 601));
      send_sample(axes_sample(512, 1022, 1023, 1023));
      req_release();
   endtask

   // Min above centre or max below it: negative slopes, truncation toward zero
   task automatic test_inconsistent_calibration();
      set_calibration(cal_word(800, 200, 100), cal_word(600, 500, 200),
                      cal_word(1023, 1023, 0), cal_word(900, 100, 1023));
      // mirrored 501 sits just above centre: 512 + 512 / -300 truncates to 511
      send_sample(axes_sample(0, 1023 - 501, 0, 0));
      send_sample(axes_sample(201, 1023, 1023, 101));
      send_sample(axes_sample(199, 1023 - 700, 512, 1023));
      send_sample(axes_sample(1023, 0, 1022, 99));
      req_release();
   endtask

   // Readings outside min..max must clamp to the rails
   task automatic test_clamping();
      set_calibration(cal_word(300, 500, 700), cal_word(300, 500, 700),
                      cal_word(300, 500, 700), cal_word(300, 500, 700));
      send_sample(axes_sample(0, 1023, 299, 1023));
      send_sample(axes_sample(1023, 0, 701, 301));
      send_sample(axes_sample(500, 1023 - 501, 501, 699));
      req_release();
   endtask

   // Hold the receiver off while the sender keeps offering, so that the
   // frame register and pipeline fill and the block drops its input ready.
   task automatic test_back_pressure();
      wait_drained();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      hold_off_left = HOLD_OFF_CYCLES;
      repeat (PRESSURE_ITEMS) send_sample(random_sample());
      req_release();
   endtask

   // Random sample sets across several calibration settings and idling mixes
   task automatic test_random_traffic();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 3)
            0: begin
               req_gap_pct   = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_gap_pct   = 25;
               rsp_stall_pct = 15;
            end
            default: begin
               req_gap_pct   = 60;
               rsp_stall_pct = 40;
            end
         endcase
         if (phase == 3)
            set_calibration('0, '0, '0, '0);
         else if (phase == 6)
            set_calibration('1, '1, '1, '1);
         else
            set_calibration(random_cal_word(), random_cal_word(),
                            random_cal_word(), random_cal_word());
         repeat (ITEMS_PER_PHASE) send_sample(random_sample());
         req_release();
      end
   endtask

   initial begin
      // Drive every input to a known value before the first edge
      req_chan.valid        = 1'b0;
      req_chan.stick1_ud    = '0;
      req_chan.stick1_lr    = '0;
      req_chan.stick2_ud    = '0;
      req_chan.stick2_lr    = '0;
      req_chan.poti_level   = '0;
      req_chan.flap_level   = '0;
      req_chan.fader_level  = '0;
      req_chan.switch_bits  = '0;
      req_chan.button_mask  = '0;
      req_chan.special_mask = '0;
      rsp_chan.ready        = 1'b0;
      csr_chan.valid        = 1'b0;
      csr_chan.index        = '0;
      csr_chan.data         = '0;
      for (int i = 0; i < NUM_CAL_REGS; i++) cal_table[i] = ccpf_pkg::CAL_RESET;
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_calibration();
      test_register_index_range();
      test_zero_denominator();
      test_inconsistent_calibration();
      test_clamping();
      test_back_pressure();
      test_random_traffic();

      // Let the last frame drain, then allow for any stray beats
      wait_drained();
      repeat (END_SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d sample sets under %0d calibration settings,",
               samples_sent, cal_settings);
      $display("including a %0d-cycle receiver hold-off; %0d frame bytes checked.",
               HOLD_OFF_CYCLES, bytes_checked);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
